FILE: rtl/core/sdf_pkg.sv
// Shared types and constants for the signed decimal field formatter.
// Holds field widths, register indexes, character codes and the
// command and status bundles between controller and datapath.
package sdf_pkg;

  // Operand and conversion sizes.
  localparam int VALUE_W    = 64;
  localparam int NUM_DIGITS = 20;
  localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
  localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);
  localparam int ITER_W     = $clog2(VALUE_W + 1);
  localparam int SHAMT_W    = $clog2(VALUE_W);

  // Character positions within one field never exceed 127.
  localparam int LEN_W = 8;

  // Output limits.
  localparam int MAX_FIELD_CHARS_DEF = 64;
  localparam int RESULT_LIMIT        = 64;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 7;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FIELD_WIDTH  = 3'd0,
    CFG_PRECISION_ON = 3'd1,
    CFG_PRECISION    = 3'd2,
    CFG_LEFT_JUSTIFY = 3'd3,
    CFG_ZERO_PAD     = 3'd4,
    CFG_SIGN_MODE    = 3'd5,
    CFG_OPERAND_SIZE = 3'd6
  } cfg_index_t;

  // Operand size codes.
  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  // ASCII codes.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic count;
    logic size;
    logic place;
    logic emit;
  } sdf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic iter_last;
    logic all_sent;
    logic emit_last;
    logic out_free;
  } sdf_sts_t;

endpackage

FILE: rtl/core/sdf_if.sv
// Handshake interfaces for the operand, text and configuration channels.
// Depends on sdf_pkg for the payload widths.

interface sdf_operand_if;
  import sdf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

interface sdf_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last;
  modport source (output valid, text_char, last, input ready);
  modport sink   (input valid, text_char, last, output ready);
endinterface

interface sdf_cfg_if;
  import sdf_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/sdf_ctrl.sv
// Sequencing state machine of the signed decimal field formatter.
// Depends on sdf_pkg for the command and status bundles.
module sdf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output sdf_pkg::sdf_cmd_t cmd,
  input  sdf_pkg::sdf_sts_t sts
);
  import sdf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_CONVERT = 6'b000010,
    S_COUNT   = 6'b000100,
    S_SIZE    = 6'b001000,
    S_PLACE   = 6'b010000,
    S_EMIT    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // A new operand is taken only between items.
  assign in_ready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CONVERT;
        end
      end
      S_CONVERT: begin
        cmd.step = 1'b1;
        if (sts.iter_last) begin
          state_next = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd.count  = 1'b1;
        state_next = S_SIZE;
      end
      S_SIZE: begin
        cmd.size   = 1'b1;
        state_next = S_PLACE;
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.all_sent) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // An accepted transaction always starts a conversion.
  a_accept_converts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CONVERT))
    else $error("accepted operand did not start a conversion");

  // A character is never loaded over one that has not been taken.
  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("character loaded into a full output register");

  // The final conversion step hands over to the digit count.
  a_convert_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONVERT && sts.iter_last) |=> (state == S_COUNT))
    else $error("conversion did not end after its last step");

endmodule

FILE: rtl/core/sdf_datapath.sv
// Datapath of the signed decimal field formatter: configuration registers,
// shift-and-add-3 binary to decimal converter, layout and character output.
// Depends on sdf_pkg and the interfaces in sdf_if.
module sdf_datapath #(
  parameter int MAX_FIELD_CHARS = sdf_pkg::MAX_FIELD_CHARS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  sdf_cfg_if.sink                            cfg,
  input  logic signed [sdf_pkg::VALUE_W-1:0] in_value,
  sdf_text_if.source                         text,
  input  sdf_pkg::sdf_cmd_t                  cmd,
  output sdf_pkg::sdf_sts_t                  sts
);
  import sdf_pkg::*;

  localparam int CAP = (MAX_FIELD_CHARS < RESULT_LIMIT) ? MAX_FIELD_CHARS : RESULT_LIMIT;

  // Configuration registers.
  logic [6:0] field_width;
  logic       precision_on;
  logic [5:0] precision;
  logic       left_justify;
  logic       zero_pad;
  logic [1:0] sign_mode;
  logic [1:0] operand_size;

  // Conversion state.
  logic [VALUE_W-1:0]          bin;
  logic [NUM_DIGITS-1:0][3:0]  bcd;
  logic [ITER_W-1:0]           iter_left;
  logic                        neg;

  // Layout state.
  logic [NDIG_W-1:0] ndig;
  logic [6:0]        body;
  logic [6:0]        pad;
  logic [LEN_W-1:0]  b1;
  logic [LEN_W-1:0]  b2;
  logic [LEN_W-1:0]  b3;
  logic [LEN_W-1:0]  b4;
  logic [LEN_W-1:0]  emit_n;
  logic [LEN_W-1:0]  p;

  // Output register.
  logic       out_valid;
  logic [7:0] out_char;
  logic       out_last;

  // Combinational helpers.
  logic [VALUE_W-1:0]         sx;
  logic [VALUE_W-1:0]         mag;
  logic [SHAMT_W-1:0]         shamt;
  logic [ITER_W-1:0]          iters;
  logic [NUM_DIGITS-1:0][3:0] bcd_adj;
  logic [NUM_DIGITS*4-1:0]    bcd_flat;
  logic [NDIG_W-1:0]          sig_cnt;
  logic                       has_sign;
  logic [7:0]                 sign_char;
  logic                       zfill;
  logic [5:0]                 nzero_calc;
  logic [6:0]                 body_calc;
  logic [LEN_W-1:0]           lead;
  logic [LEN_W-1:0]           b1_calc;
  logic [LEN_W-1:0]           b4_calc;
  logic [LEN_W-1:0]           total;
  logic [LEN_W-1:0]           idx_full;
  logic [DIG_IDX_W-1:0]       dig_idx;
  logic [3:0]                 digit;
  logic [7:0]                 ch;

  // Configuration writes; the port never stalls.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_width  <= '0;
      precision_on <= 1'b0;
      precision    <= '0;
      left_justify <= 1'b0;
      zero_pad     <= 1'b0;
      sign_mode    <= '0;
      operand_size <= SIZE_32;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_FIELD_WIDTH:  field_width  <= cfg.data[6:0];
        CFG_PRECISION_ON: precision_on <= cfg.data[0];
        CFG_PRECISION:    precision    <= cfg.data[5:0];
        CFG_LEFT_JUSTIFY: left_justify <= cfg.data[0];
        CFG_ZERO_PAD:     zero_pad     <= cfg.data[0];
        CFG_SIGN_MODE:    sign_mode    <= cfg.data[1:0];
        CFG_OPERAND_SIZE: operand_size <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

  // Narrow and sign-extend the operand, then align its magnitude to the top.
  always_comb begin
    unique case (operand_size)
      SIZE_8: begin
        sx    = {{(VALUE_W-8){in_value[7]}}, in_value[7:0]};
        shamt = SHAMT_W'(VALUE_W - 8);
        iters = ITER_W'(8);
      end
      SIZE_16: begin
        sx    = {{(VALUE_W-16){in_value[15]}}, in_value[15:0]};
        shamt = SHAMT_W'(VALUE_W - 16);
        iters = ITER_W'(16);
      end
      SIZE_32: begin
        sx    = {{(VALUE_W-32){in_value[31]}}, in_value[31:0]};
        shamt = SHAMT_W'(VALUE_W - 32);
        iters = ITER_W'(32);
      end
      default: begin
        sx    = in_value;
        shamt = '0;
        iters = ITER_W'(VALUE_W);
      end
    endcase
    mag = sx[VALUE_W-1] ? (~sx + VALUE_W'(1)) : sx;
  end

  // Add 3 to every decimal digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? (bcd[i] + 4'd3) : bcd[i];
    end
  end

  assign bcd_flat = bcd_adj;

  // Number of significant digits, at least one.
  always_comb begin
    sig_cnt = NDIG_W'(1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i] != 4'd0) begin
        sig_cnt = NDIG_W'(i + 1);
      end
    end
  end

  // Converter registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin       <= mag << shamt;
      bcd       <= '0;
      iter_left <= iters;
      neg       <= sx[VALUE_W-1];
    end else if (cmd.step) begin
      bcd       <= {bcd_flat[NUM_DIGITS*4-2:0], bin[VALUE_W-1]};
      bin       <= bin << 1;
      iter_left <= iter_left - ITER_W'(1);
    end
  end

  // Sign character and fill mode.
  assign has_sign  = neg || (sign_mode != 2'd0);
  assign sign_char = neg ? CHAR_MINUS : (sign_mode[1] ? CHAR_PLUS : CHAR_SPACE);
  assign zfill     = zero_pad && !precision_on && !left_justify;

  // Precision zeros and the length of sign, zeros and digits.
  assign nzero_calc = (precision_on && (precision > 6'(ndig))) ? (precision - 6'(ndig)) : '0;
  assign body_calc  = 7'(ndig) + 7'(nzero_calc) + 7'(has_sign);

  // Boundaries of the padding, sign, zero and digit runs.
  assign lead    = (!left_justify && !zfill) ? LEN_W'(pad) : '0;
  assign b1_calc = lead;
  assign b4_calc = (left_justify ? '0 : LEN_W'(pad)) + LEN_W'(body);
  assign total   = LEN_W'(pad) + LEN_W'(body);

  // Layout registers.
  always_ff @(posedge clk) begin
    if (cmd.count) begin
      ndig <= ((bcd == '0) && precision_on && (precision == 6'd0)) ? '0 : sig_cnt;
    end
    if (cmd.size) begin
      body  <= body_calc;
      pad   <= (field_width > body_calc) ? (field_width - body_calc) : '0;
    end
    if (cmd.place) begin
      b1     <= b1_calc;
      b2     <= b1_calc + LEN_W'(has_sign);
      b3     <= b4_calc - LEN_W'(ndig);
      b4     <= b4_calc;
      emit_n <= (total > LEN_W'(CAP)) ? LEN_W'(CAP) : total;
      p      <= '0;
    end else if (cmd.emit) begin
      p <= p + LEN_W'(1);
    end
  end

  // Character at the current position; digits are read from the top down.
  assign idx_full = b4 - LEN_W'(1) - p;
  assign dig_idx  = idx_full[DIG_IDX_W-1:0];
  assign digit    = (idx_full < LEN_W'(NUM_DIGITS)) ? bcd[dig_idx] : 4'd0;

  always_comb begin
    priority if (p < b1) begin
      ch = zfill ? CHAR_ZERO : CHAR_SPACE;
    end else if (p < b2) begin
      ch = sign_char;
    end else if (p < b3) begin
      ch = CHAR_ZERO;
    end else if (p < b4) begin
      ch = CHAR_ZERO | {4'd0, digit};
    end else begin
      ch = CHAR_SPACE;
    end
  end

  // Output register parts the datapath from the text channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (text.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char <= ch;
      out_last <= (p + LEN_W'(1) == emit_n);
    end
  end

  assign text.valid     = out_valid;
  assign text.text_char = out_char;
  assign text.last      = out_last;

  // Status towards the controller.
  assign sts.iter_last = (iter_left == ITER_W'(1));
  assign sts.all_sent  = (p == emit_n);
  assign sts.emit_last = (p + LEN_W'(1) == emit_n);
  assign sts.out_free  = !out_valid || text.ready;

  // A conversion step always has a bit left to take in.
  a_step_has_bits: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (iter_left != '0))
    else $error("conversion step with no bits left");

  // No character is loaded beyond the emitted length.
  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (p < emit_n))
    else $error("character loaded past the end of the field");

  // Loading the final character presents a valid result marked last.
  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && sts.emit_last) |=> (out_valid && out_last && (p == emit_n)))
    else $error("final character not marked last");

endmodule

FILE: rtl/core/signed_decimal_field_formatter.sv
// Signed decimal field formatter: one operand in, its %d text out as one
// ASCII character per transaction with a last marker on the final one. The
// operand is narrowed to 8, 16, 32 or 64 bits and converted by a shift-and-
// add-3 converter that takes one bit per cycle. Digit count, size and place
// steps then count digits and lay out the field, and characters leave at one
// per cycle while the text channel is ready. The next operand is accepted
// once the final character sits in the output register. An item that
// yields no characters emits nothing.
// Configuration writes are taken at any time but must only be made while
// the block is idle.
module signed_decimal_field_formatter #(
  parameter int MAX_FIELD_CHARS = sdf_pkg::MAX_FIELD_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sdf_cfg_if.sink     cfg,
  sdf_operand_if.sink operand,
  sdf_text_if.source  text
);
  import sdf_pkg::*;

  sdf_cmd_t cmd;
  sdf_sts_t sts;

  // Sequencer.
  sdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (operand.valid),
    .in_ready (operand.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Converter, layout and output register.
  sdf_datapath #(
    .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_value (operand.value),
    .text     (text),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

FILE: tb/sv/tb_signed_decimal_field_formatter.sv
// Self-checking testbench for the signed decimal field formatter: directed and random
// operands under many register settings, with random idling and a long output stall.
// Depends on sdf_pkg and the handshake interfaces in sdf_if.
module tb_signed_decimal_field_formatter;
  import sdf_pkg::*;

  localparam int TEXT_CAP       = (MAX_FIELD_CHARS_DEF < RESULT_LIMIT) ?
                                  MAX_FIELD_CHARS_DEF : RESULT_LIMIT;
  localparam int DRAIN_CYCLES   = 140;
  localparam int STALL_CYCLES   = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES  = 11;
  localparam int PHASE_ITEMS    = 25;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  logic clk = 1'b0;
  logic rst;

  sdf_cfg_if     cfg_ch();
  sdf_operand_if operand_ch();
  sdf_text_if    text_ch();

  signed_decimal_field_formatter uut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .operand (operand_ch),
    .text    (text_ch)
  );

  // Local copy of the format registers, updated as each write transaction completes.
  logic [6:0] fmt_width     = 7'd0;
  logic       fmt_prec_on   = 1'b0;
  logic [5:0] fmt_prec      = 6'd0;
  logic       fmt_left      = 1'b0;
  logic       fmt_zero_pad  = 1'b0;
  logic [1:0] fmt_sign_mode = 2'd0;
  logic [1:0] fmt_size      = SIZE_32;

  text_beat_t pending_chars[$];
  text_beat_t want_beat;
  int         mismatches       = 0;
  int         values_sent      = 0;
  int         chars_checked    = 0;
  int         settings_applied = 0;
  int         quiet_cycles     = 0;
  logic       steady_flow      = 1'b0;
  logic       stall_request    = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Work out the characters one operand should produce under the current settings.
  function automatic void predict_field_text(input logic [63:0] v);
    logic [63:0] narrowed;
    logic [63:0] mag;
    logic        neg;
    logic        has_sign;
    logic        zfill;
    logic [7:0]  sign_ch;
    logic [7:0]  digits[$];
    logic [7:0]  line[$];
    int          nzero;
    int          body;
    int          pad;
    int          n_out;
    text_beat_t  beat;
    case (fmt_size)
      SIZE_8:  narrowed = {{56{v[7]}}, v[7:0]};
      SIZE_16: narrowed = {{48{v[15]}}, v[15:0]};
      SIZE_32: narrowed = {{32{v[31]}}, v[31:0]};
      default: narrowed = v;
    endcase
    neg = narrowed[63];
    mag = neg ? (64'd0 - narrowed) : narrowed;

    // Digits are gathered least significant first; zero with precision zero has none.
    if (!(mag == 64'd0 && fmt_prec_on && fmt_prec == 6'd0)) begin
      do begin
        digits.push_back(CHAR_ZERO + 8'(mag % 64'd10));
        mag = mag / 64'd10;
      end while (mag != 64'd0);
    end
    nzero = (fmt_prec_on && int'(fmt_prec) > digits.size()) ?
            int'(fmt_prec) - digits.size() : 0;

    // Sign selector three acts as the plus selector.
    has_sign = 1'b1;
    if (neg) sign_ch = CHAR_MINUS;
    else if (fmt_sign_mode[1]) sign_ch = CHAR_PLUS;
    else if (fmt_sign_mode[0]) sign_ch = CHAR_SPACE;
    else begin
      sign_ch  = CHAR_SPACE;
      has_sign = 1'b0;
    end

    body  = digits.size() + nzero + (has_sign ? 1 : 0);
    pad   = (int'(fmt_width) > body) ? int'(fmt_width) - body : 0;
    zfill = fmt_zero_pad && !fmt_prec_on && !fmt_left;

    // Space padding goes before the sign, zero padding after it.
    if (!fmt_left && !zfill) repeat (pad) line.push_back(CHAR_SPACE);
    if (has_sign) line.push_back(sign_ch);
    if (zfill) repeat (pad) line.push_back(CHAR_ZERO);
    repeat (nzero) line.push_back(CHAR_ZERO);
    for (int i = digits.size() - 1; i >= 0; i--) line.push_back(digits[i]);
    if (fmt_left) repeat (pad) line.push_back(CHAR_SPACE);

    // Overlong text is cut at the character limit.
    n_out = (line.size() < TEXT_CAP) ? line.size() : TEXT_CAP;
    for (int i = 0; i < n_out; i++) begin
      beat.ch   = line[i];
      beat.last = (i == n_out - 1);
      pending_chars.push_back(beat);
    end
  endfunction

  // Operands biased towards the interesting corners of each operand size.
  function automatic logic [63:0] pick_value();
    logic [63:0]        r;
    logic [63:0]        base;
    logic [63:0]        msb;
    logic signed [31:0] s;
    int unsigned        k;
    r = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0: return r;
      1: begin
        s = $urandom_range(0, 2000);
        s = s - 32'sd1000;
        return {{32{s[31]}}, s};
      end
      2: return $urandom_range(0, 1) ? 64'd0 : {r[63:8], 8'h00};
      3: begin
        k   = 8 << $urandom_range(0, 3);
        msb = 64'd1 << (k - 1);
        case ($urandom_range(0, 3))
          0: base = msb;
          1: base = msb - 64'd1;
          2: base = '1;
          default: base = 64'd1;
        endcase
        // Leave random bits above the operand size; they must be ignored.
        return (r << k) | (base & ((64'd1 << k) - 64'd1));
      end
      4: begin
        base = {$urandom(), $urandom()} >> $urandom_range(0, 63);
        return $urandom_range(0, 1) ? (64'd0 - base) : base;
      end
      default: return r;
    endcase
  endfunction

  // Offer one operand, with an occasional idle burst first, and predict its text.
  task automatic send_value(input logic [63:0] v);
    if (!steady_flow && $urandom_range(0, 3) == 0) begin
      operand_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    operand_ch.valid <= 1'b1;
    operand_ch.value <= v;
    do @(posedge clk); while (!operand_ch.ready);
    predict_field_text(v);
    values_sent++;
  endtask

  // Stop offering, let every expected character arrive, then allow for an item
  // still in conversion that produces no text.
  task automatic wait_idle();
    operand_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_FIELD_WIDTH:  fmt_width     = data[6:0];
      CFG_PRECISION_ON: fmt_prec_on   = data[0];
      CFG_PRECISION:    fmt_prec      = data[5:0];
      CFG_LEFT_JUSTIFY: fmt_left      = data[0];
      CFG_ZERO_PAD:     fmt_zero_pad  = data[0];
      CFG_SIGN_MODE:    fmt_sign_mode = data[1:0];
      CFG_OPERAND_SIZE: fmt_size      = data[1:0];
      default: ;
    endcase
  endtask

  // Rewrite every register once the block has gone idle.
  task automatic set_format(input logic [6:0] width, input logic prec_on,
                            input logic [5:0] prec, input logic left,
                            input logic zero_pad, input logic [1:0] sign_mode,
                            input logic [1:0] size);
    wait_idle();
    write_reg(CFG_FIELD_WIDTH, width);
    write_reg(CFG_PRECISION_ON, 7'(prec_on));
    write_reg(CFG_PRECISION, 7'(prec));
    write_reg(CFG_LEFT_JUSTIFY, 7'(left));
    write_reg(CFG_ZERO_PAD, 7'(zero_pad));
    write_reg(CFG_SIGN_MODE, 7'(sign_mode));
    write_reg(CFG_OPERAND_SIZE, 7'(size));
    cfg_ch.valid <= 1'b0;
    settings_applied++;
  endtask

  // Registers as they come out of reset: 32-bit operands, no padding.
  task automatic test_reset_defaults();
    send_value(64'd0);
    send_value('1);
    send_value(64'h0000_0000_7FFF_FFFF);
    send_value(64'hFFFF_FFFF_8000_0000);
    send_value(64'h1234_5678_0000_0005);
  endtask

  // Field extremes, every sign selector and the documented corner cases.
  task automatic test_directed_cases();
    set_format(7'd0, 1'b0, 6'd0, 1'b0, 1'b0, 2'd0, SIZE_64);
    send_value(64'h8000_0000_0000_0000);
    send_value(64'h7FFF_FFFF_FFFF_FFFF);
    // Zero padding after a space sign on 8-bit operands with junk above.
    set_format(7'd6, 1'b0, 6'd0, 1'b0, 1'b1, 2'd1, SIZE_8);
    send_value(64'd127);
    send_value(64'h1234_5678_9ABC_DE80);
    send_value(64'hA5A5_A5A5_A5A5_A5FF);
    // Zero padding is ignored when left-justified.
    set_format(7'd9, 1'b0, 6'd0, 1'b1, 1'b1, 2'd2, SIZE_16);
    send_value(64'h0000_0000_0000_8000);
    send_value(64'hFFFF_FFFF_FFFF_0000);
    // Zero with precision zero and nothing else yields no text at all.
    set_format(7'd0, 1'b1, 6'd0, 1'b0, 1'b0, 2'd0, SIZE_32);
    send_value(64'hFFFF_FFFF_0000_0000);
    send_value(64'd5);
    // Zero with precision zero still gets its sign and padding; zero padding is
    // ignored when a precision is given.
    set_format(7'd4, 1'b1, 6'd0, 1'b0, 1'b1, 2'd3, SIZE_32);
    send_value(64'd0);
    // Widths beyond the character limit are cut.
    set_format(7'd127, 1'b0, 6'd0, 1'b0, 1'b0, 2'd0, SIZE_64);
    send_value('1);
    set_format(7'd127, 1'b0, 6'd0, 1'b0, 1'b1, 2'd2, SIZE_64);
    send_value(64'd42);
    // Largest precision fills the whole field.
    set_format(7'd64, 1'b1, 6'd63, 1'b1, 1'b0, 2'd0, SIZE_64);
    send_value('1);
    send_value(64'h8000_0000_0000_0000);
    set_format(7'd3, 1'b1, 6'd2, 1'b0, 1'b0, 2'd1, SIZE_8);
    send_value(64'd7);
    send_value(64'h0000_0000_0000_0080);
  endtask

  // A fresh random format for each phase, with the extremes now and then.
  task automatic pick_random_format();
    logic [6:0] width;
    logic [5:0] prec;
    width = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(21, 127)) :
                                          7'($urandom_range(0, 20));
    prec  = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(13, 63)) :
                                          6'($urandom_range(0, 12));
    if ($urandom_range(0, 5) == 0) width = $urandom_range(0, 1) ? 7'd127 : 7'd0;
    if ($urandom_range(0, 5) == 0) prec  = $urandom_range(0, 1) ? 6'd63 : 6'd0;
    set_format(width, 1'($urandom_range(0, 1)), prec, 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
               2'($urandom_range(0, 3)));
  endtask

  task automatic test_random_formats();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pick_random_format();
      repeat (PHASE_ITEMS) send_value(pick_value());
    end
  endtask

  // The receiver holds off for a long stretch while operands keep coming.
  task automatic test_output_stall();
    pick_random_format();
    stall_request = 1'b1;
    repeat (16) send_value(pick_value());
  endtask

  // Closing stretch with neither side idling.
  task automatic test_steady_stream();
    pick_random_format();
    steady_flow = 1'b1;
    repeat (30) send_value(pick_value());
  endtask

  // Receiver: random ready bursts, plus the long hold-off on request.
  initial begin
    text_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        text_ch.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        text_ch.ready <= 1'b1;
      end else if (!steady_flow && $urandom_range(0, 5) == 0) begin
        text_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        text_ch.ready <= 1'b1;
      end else begin
        text_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each character transaction with the oldest expected character.
  always @(posedge clk) begin
    if (!rst && text_ch.valid && text_ch.ready) begin
      chars_checked++;
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected character 0x%02h last=%0b with nothing pending",
                   text_ch.text_char, text_ch.last);
      end else begin
        want_beat = pending_chars.pop_front();
        if (want_beat.ch !== text_ch.text_char || want_beat.last !== text_ch.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Character mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                     want_beat.ch, want_beat.last, text_ch.text_char, text_ch.last);
        end
      end
    end
  end

  // Watchdog: give up when no transaction has completed for too long.
  always @(posedge clk) begin
    if (rst || (cfg_ch.valid && cfg_ch.ready) || (operand_ch.valid && operand_ch.ready) ||
        (text_ch.valid && text_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d characters outstanding",
               WATCHDOG_LIMIT, pending_chars.size());
      $display("** signed_decimal_field_formatter: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst              = 1'b1;
    operand_ch.valid = 1'b0;
    operand_ch.value = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_FIELD_WIDTH;
    cfg_ch.data      = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_cases();
    test_random_formats();
    test_output_stall();
    test_steady_stream();
    wait_idle();

    $display("Formatted %0d operands into %0d characters across %0d register settings,",
             values_sent, chars_checked, settings_applied);
    $display("including a %0d-cycle receiver stall; %0d mismatches.",
             STALL_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("** signed_decimal_field_formatter: PASSED **");
    end else begin
      $display("** signed_decimal_field_formatter: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sdf_pkg.sv
rtl/core/sdf_if.sv
rtl/core/sdf_ctrl.sv
rtl/core/sdf_datapath.sv
rtl/core/signed_decimal_field_formatter.sv
tb/sv/tb_signed_decimal_field_formatter.sv
